// File: hdl/two_choice_bucketed_hash_lookup_macros.svh
// assertion macros used by the hash lookup top level
`ifndef TWO_CHOICE_BUCKETED_HASH_LOOKUP_MACROS_SVH
`define TWO_CHOICE_BUCKETED_HASH_LOOKUP_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, clocked on clk, off while rst_n is low
`define TCBHL_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("same-cycle check failed");
// next-cycle implication
`define TCBHL_ASSERT_NXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("next-cycle check failed");
`else
`define TCBHL_ASSERT_IMP(lbl, a, b)
`define TCBHL_ASSERT_NXT(lbl, a, b)
`endif
`endif

// File: hdl/tcbhl_pkg.sv
// types, hash constants and helpers for the hash lookup block
`timescale 1ns / 1ps
package tcbhl_pkg;

  localparam int KEY_W      = 32;
  localparam int PORT_W     = 4;
  localparam int SLOT_W     = KEY_W + PORT_W;
  localparam int SLOT_IDX_W = 4;

  localparam logic KIND_LOOKUP = 1'b0;
  localparam logic KIND_INSERT = 1'b1;

  localparam logic [31:0] CH_C1  = 32'hcc9e2d51;
  localparam logic [31:0] CH_C2  = 32'h1b873593;
  localparam logic [31:0] CH_ADD = 32'he6546b64;
  localparam logic [31:0] FM_M1  = 32'h85ebca6b;
  localparam logic [31:0] FM_M2  = 32'hc2b2ae35;
  localparam logic [31:0] SEED_C = 32'd9;
  localparam logic [31:0] MUL5   = 32'd5;

  function automatic logic [31:0] rotr32(input logic [31:0] v, input int s);
    rotr32 = (v >> s) | (v << (32 - s));
  endfunction

  // mixed length word: rotr(4 * c1, 17) * c2
  localparam logic [31:0] LEN_PRE = 32'(32'd4 * CH_C1);
  localparam logic [31:0] LEN_MIX = 32'(rotr32(LEN_PRE, 17) * CH_C2);

  typedef struct packed {
    logic                  kind;
    logic [KEY_W-1:0]      key;
    logic                  use_second;
    logic [2:0]            victim_slot;
    logic [PORT_W-1:0]     port_in;
  } req_t;

  typedef struct packed {
    logic              hit;
    logic [PORT_W-1:0] port_out;
    logic              replaced;
  } rsp_t;

  typedef struct packed {
    logic [PORT_W-1:0] port;
    logic [KEY_W-1:0]  key;
  } slot_t;

  typedef struct packed {
    logic                  hit;
    logic [PORT_W-1:0]     port;
    logic                  has_empty;
    logic [SLOT_IDX_W-1:0] empty_idx;
  } bkt_match_t;

  typedef enum logic [3:0] {
    HS_IDLE, HS_B0, HS_B1, HS_B2, HS_B3, HS_M4, HS_M5, HS_M6, HS_M7, HS_F1, HS_F2
  } hstep_t;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_HASH, ST_READ, ST_CHECK
  } st_t;

endpackage

// File: hdl/tcbhl_ram.sv
// generic single-port ram with registered read
`timescale 1ns / 1ps
module tcbhl_ram #(
  parameter int WIDTH = 288,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/tcbhl_hash.sv
// sequenced 32-bit word hash over one shared multiply-add unit
`timescale 1ns / 1ps
module tcbhl_hash (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] word,
  output logic        done,
  output logic [31:0] result
);
  import tcbhl_pkg::*;

  hstep_t      step_r, step_nxt;
  logic        done_r, done_nxt;
  logic [31:0] word_r, b_r, c_r, h_r;
  logic [31:0] b_nxt, c_nxt, h_nxt;
  logic [31:0] op_a, op_b, op_add, prod;
  logic [7:0]  byte_sel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= HS_IDLE;
      done_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      word_r <= word;
    end
    b_r <= b_nxt;
    c_r <= c_nxt;
    h_r <= h_nxt;
  end

  // the one multiplier, low half plus addend
  assign prod = 32'(op_a * op_b) + op_add;

  always_comb begin
    step_nxt = step_r;
    done_nxt = 1'b0;
    b_nxt    = b_r;
    c_nxt    = c_r;
    h_nxt    = h_r;
    op_a     = b_r;
    op_b     = CH_C1;
    op_add   = '0;
    byte_sel = word_r[7:0];
    case (step_r)
      HS_IDLE: begin
        if (start) begin
          step_nxt = HS_B0;
          b_nxt    = '0;
          c_nxt    = SEED_C;
        end
      end
      HS_B0, HS_B1, HS_B2, HS_B3: begin
        case (step_r)
          HS_B1:   byte_sel = word_r[15:8];
          HS_B2:   byte_sel = word_r[23:16];
          HS_B3:   byte_sel = word_r[31:24];
          default: byte_sel = word_r[7:0];
        endcase
        // bytes enter sign extended
        op_add   = {{24{byte_sel[7]}}, byte_sel};
        b_nxt    = prod;
        c_nxt    = c_r ^ prod;
        step_nxt = hstep_t'(step_r + 4'd1);
      end
      HS_M4: begin
        op_a     = rotr32(c_r ^ LEN_MIX, 19);
        op_b     = MUL5;
        op_add   = CH_ADD;
        h_nxt    = prod;
        step_nxt = HS_M5;
      end
      HS_M5: begin
        b_nxt    = prod;
        step_nxt = HS_M6;
      end
      HS_M6: begin
        op_a     = rotr32(b_r, 17);
        op_b     = CH_C2;
        b_nxt    = prod;
        step_nxt = HS_M7;
      end
      HS_M7: begin
        op_a     = rotr32(h_r ^ b_r, 19);
        op_b     = MUL5;
        op_add   = CH_ADD;
        h_nxt    = prod;
        step_nxt = HS_F1;
      end
      HS_F1: begin
        op_a     = h_r ^ (h_r >> 16);
        op_b     = FM_M1;
        h_nxt    = prod;
        step_nxt = HS_F2;
      end
      HS_F2: begin
        op_a     = h_r ^ (h_r >> 13);
        op_b     = FM_M2;
        h_nxt    = prod;
        step_nxt = HS_IDLE;
        done_nxt = 1'b1;
      end
      default: step_nxt = HS_IDLE;
    endcase
  end

  assign done   = done_r;
  assign result = h_r ^ (h_r >> 16);

endmodule

// File: hdl/tcbhl_match.sv
// compares one bucket row against a key and finds the first empty slot
`timescale 1ns / 1ps
module tcbhl_match #(
  parameter int SLOTS = 8
) (
  input  logic [SLOTS*tcbhl_pkg::SLOT_W-1:0] row,
  input  logic [tcbhl_pkg::KEY_W-1:0]        key,
  output tcbhl_pkg::bkt_match_t              match
);
  import tcbhl_pkg::*;

  slot_t slot;

  // walk from the top so the lowest slot wins
  always_comb begin
    match = '0;
    slot  = '0;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      slot = row[s*SLOT_W +: SLOT_W];
      if (slot.key == key) begin
        match.hit  = 1'b1;
        match.port = slot.port;
      end
      if (slot.key == '0) begin
        match.has_empty = 1'b1;
        match.empty_idx = SLOT_IDX_W'(s);
      end
    end
  end

endmodule

// File: hdl/two_choice_bucketed_hash_lookup.sv
// top level: two-choice bucketed hash table with lookup and insert
`timescale 1ns / 1ps
`include "two_choice_bucketed_hash_lookup_macros.svh"
// Forwarding table of BUCKETS rows, each holding SLOTS slots of a 32-bit key
// and a 4-bit port; key zero marks an empty slot. A request is taken when
// start is high and busy is low; exactly one result follows, shown on out_rsp
// for one cycle with out_valid high, and the receiver cannot stall it, so it
// must take every result in the cycle it appears. After reset the block runs
// a clearing pass over all BUCKETS rows, one row per cycle, with busy high.
// Work per request, all done by the single shared multiply-add in the hash
// unit (10 steps per hash) and the one-port row memory:
//   key zero: busy never rises, result with no table access
//   insert in first bucket, or lookup hit in first bucket: hash, read, compare
//   insert in second bucket: two hashes, then read, compare; lookup needing
//   the second bucket: hash, read, compare, then hash, read, compare again
// busy drops in the cycle the result is shown, so the next request can be
// taken at the edge that ends it
// Each bucket probe is one row read and a parallel compare of all slots;
// an insert writes the updated row back in the compare cycle.
module two_choice_bucketed_hash_lookup #(
  parameter int BUCKETS = 4096,
  parameter int SLOTS   = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  tcbhl_pkg::req_t   in_req,
  output logic              busy,
  output logic              out_valid,
  output tcbhl_pkg::rsp_t   out_rsp
);
  import tcbhl_pkg::*;

  localparam int BW    = $clog2(BUCKETS);
  localparam int SIW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int ROW_W = SLOTS * SLOT_W;

  // state and request registers
  st_t             state_r, state_nxt;
  logic            second_r, second_nxt;
  logic [BW-1:0]   bucket_r, bucket_nxt;
  logic [BW-1:0]   clr_cnt_r, clr_cnt_nxt;
  req_t            req_r;
  logic            out_valid_r, out_valid_nxt;
  rsp_t            out_rsp_r, out_rsp_nxt;

  // hash unit hookup
  logic            hash_start;
  logic [31:0]     hash_word;
  logic            hash_done;
  logic [31:0]     hash_result;
  logic [BW-1:0]   hash_bucket;

  // row memory
  logic            ram_we;
  logic [BW-1:0]   ram_addr;
  logic [ROW_W-1:0] ram_wdata, ram_rdata, new_row;
  bkt_match_t      match;
  logic [SIW-1:0]  victim_idx, ins_idx;
  logic            accept;

  // victim slot wraps modulo the slot count
  function automatic logic [SIW-1:0] wrap_slot(input logic [2:0] v);
    logic [4:0] r;
    r = {2'b00, v};
    for (int i = 0; i < 8; i++) begin
      if (r >= 5'(SLOTS)) begin
        r = r - 5'(SLOTS);
      end
    end
    wrap_slot = SIW'(r);
  endfunction

  tcbhl_hash u_hash (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (hash_start),
    .word   (hash_word),
    .done   (hash_done),
    .result (hash_result)
  );

  tcbhl_ram #(
    .WIDTH (ROW_W),
    .DEPTH (BUCKETS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  tcbhl_match #(
    .SLOTS (SLOTS)
  ) u_match (
    .row   (ram_rdata),
    .key   (req_r.key),
    .match (match)
  );

  assign accept      = start && !busy;
  // bucket index is the hash masked by BUCKETS-1
  assign hash_bucket = hash_result[BW-1:0] & BW'(BUCKETS - 1);
  assign victim_idx  = wrap_slot(req_r.victim_slot);
  assign ins_idx     = match.has_empty ? match.empty_idx[SIW-1:0] : victim_idx;

  // row with the chosen slot replaced by the new entry
  always_comb begin
    new_row = ram_rdata;
    new_row[ins_idx*SLOT_W +: SLOT_W] = {req_r.port_in, req_r.key};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      second_r    <= 1'b0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      second_r    <= second_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_req;
    end
    bucket_r  <= bucket_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    second_nxt    = second_r;
    bucket_nxt    = bucket_r;
    clr_cnt_nxt   = clr_cnt_r;
    out_valid_nxt = 1'b0;
    out_rsp_nxt   = out_rsp_r;
    hash_start    = 1'b0;
    hash_word     = in_req.key;
    ram_we        = 1'b0;
    ram_addr      = bucket_r;
    ram_wdata     = new_row;
    case (state_r)
      ST_CLEAR: begin
        // zero one row per cycle
        ram_we      = 1'b1;
        ram_addr    = clr_cnt_r;
        ram_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == BW'(BUCKETS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          second_nxt = 1'b0;
          if (in_req.key == '0) begin
            // reserved key: no table access, all-zero result
            out_valid_nxt = 1'b1;
            out_rsp_nxt   = '0;
          end else begin
            hash_start = 1'b1;
            state_nxt  = ST_HASH;
          end
        end
      end
      ST_HASH: begin
        hash_word = 32'(bucket_r);
        if (hash_done) begin
          bucket_nxt = hash_bucket;
          if (!second_r && req_r.kind == KIND_INSERT && req_r.use_second) begin
            // second bucket comes from hashing the first bucket index
            hash_start = 1'b1;
            hash_word  = 32'(hash_bucket);
            second_nxt = 1'b1;
          end else begin
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ: begin
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        hash_word = 32'(bucket_r);
        if (req_r.kind == KIND_INSERT) begin
          ram_we        = 1'b1;
          out_valid_nxt = 1'b1;
          out_rsp_nxt   = '{hit: 1'b0, port_out: '0, replaced: !match.has_empty};
          state_nxt     = ST_IDLE;
        end else if (match.hit) begin
          out_valid_nxt = 1'b1;
          out_rsp_nxt   = '{hit: 1'b1, port_out: match.port, replaced: 1'b0};
          state_nxt     = ST_IDLE;
        end else if (!second_r) begin
          // miss in first bucket: go find the second one
          hash_start = 1'b1;
          second_nxt = 1'b1;
          state_nxt  = ST_HASH;
        end else begin
          out_valid_nxt = 1'b1;
          out_rsp_nxt   = '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  `TCBHL_ASSERT_IMP(a_ins_no_hit, out_valid_r && out_rsp_r.replaced, !out_rsp_r.hit)
  `TCBHL_ASSERT_IMP(a_hash_in_hash, hash_done, state_r == ST_HASH)
  `TCBHL_ASSERT_NXT(a_req_progress, accept, out_valid_r || busy)
  `TCBHL_ASSERT_IMP(a_write_when_owned, ram_we, state_r == ST_CLEAR || state_r == ST_CHECK)

endmodule
